@@ src/vcsim_pkg.sv @@
// ----------------------------------------------------------------------------
// vcsim_pkg
// Shared types and constants of the vector cosine similarity core.
// ----------------------------------------------------------------------------
package vcsim_pkg;

    localparam int ELEM_WIDTH_DEF = 16;
    localparam int MAX_LENGTH_DEF = 4096;
    localparam int ACC_W_DEF      = 2 * ELEM_WIDTH_DEF - 1 + $clog2(MAX_LENGTH_DEF);

    // similarity result format, signed q1.14
    localparam int SIM_W     = 16;
    localparam int FRAC_BITS = 14;

    localparam logic [SIM_W-1:0]        ONE_Q14 = 16'd16384;
    localparam logic signed [SIM_W-1:0] SIM_MAX = 16'sd16384;
    localparam logic signed [SIM_W-1:0] SIM_MIN = -16'sd16384;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_AB,
        ST_MUL_AA,
        ST_MUL_BB,
        ST_ACC_NB,
        ST_START,
        ST_CALC,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        EP_IDLE,
        EP_MUL,
        EP_ROOT,
        EP_DIV,
        EP_FIN
    } t_eng_phase;

endpackage

@@ src/vcsim_engine.sv @@
// ----------------------------------------------------------------------------
// vcsim_engine
// Back end: norm product by shift-add, integer square root digit by digit and
// restoring division, all through one shared add/subtract unit.
// ----------------------------------------------------------------------------
module vcsim_engine #(
    parameter int ACC_W = vcsim_pkg::ACC_W_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [ACC_W-1:0]           i_dot,
    input  logic [ACC_W-1:0]                  i_norm_a,
    input  logic [ACC_W-1:0]                  i_norm_b,
    output logic                              o_done,
    output logic signed [vcsim_pkg::SIM_W-1:0] o_result
);
    import vcsim_pkg::*;

    localparam int PW = 2 * ACC_W;          // norm product
    localparam int RW = ACC_W + 2;          // root / division remainder
    localparam int DW = ACC_W + FRAC_BITS;  // scaled dividend
    localparam int UW = PW + 1;             // shared unit, top bit is the borrow
    localparam int CW = $clog2(DW);

    t_eng_phase r_phase;
    t_eng_phase n_phase;

    logic [CW-1:0]    r_cnt;
    logic [PW-1:0]    r_acc;
    logic [ACC_W-1:0] r_na;
    logic [ACC_W-1:0] r_mpl;
    logic [RW-1:0]    r_rem;
    logic [ACC_W-1:0] r_root;
    logic [DW-1:0]    r_dvd;
    logic [SIM_W-1:0] r_q;
    logic             r_big;
    logic             r_neg;
    logic             r_done;
    logic signed [SIM_W-1:0] r_result;

    logic             na_zero;
    logic             nb_zero;
    logic             dot_neg;
    logic [ACC_W-1:0] dot_mag;
    logic [RW-1:0]    root_sh;
    logic [ACC_W:0]   div_sh;
    logic [UW-1:0]    au_x;
    logic [UW-1:0]    au_y;
    logic             au_sub;
    logic [UW-1:0]    au_sum;
    logic             au_borrow;
    logic             q_sat;
    logic [SIM_W-1:0] q_mag;

    assign na_zero = (i_norm_a == '0);
    assign nb_zero = (i_norm_b == '0);
    assign dot_neg = i_dot[ACC_W-1];
    assign dot_mag = dot_neg ? (~i_dot + ACC_W'(1)) : i_dot;

    assign root_sh = {r_rem[RW-3:0], r_acc[PW-1:PW-2]};
    assign div_sh  = {r_rem[ACC_W-1:0], r_dvd[DW-1]};

    // shared add / subtract unit
    always_comb begin
        au_x   = '0;
        au_y   = '0;
        au_sub = 1'b0;
        unique case (r_phase)
            EP_MUL: begin
                au_x = UW'({r_acc[PW-2:0], 1'b0});
                au_y = r_mpl[ACC_W-1] ? UW'(r_na) : '0;
            end
            EP_ROOT: begin
                au_x   = UW'(root_sh);
                au_y   = UW'({r_root, 2'b01});
                au_sub = 1'b1;
            end
            EP_DIV: begin
                au_x   = UW'(div_sh);
                au_y   = UW'(r_root);
                au_sub = 1'b1;
            end
            default: ;
        endcase
    end

    assign au_sum    = au_x + (au_sub ? ~au_y : au_y) + UW'(au_sub);
    assign au_borrow = au_sum[UW-1];

    assign q_sat = r_big || (r_q > ONE_Q14);
    assign q_mag = q_sat ? ONE_Q14 : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= EP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == EP_FIN);
        end
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            EP_IDLE: begin
                if (i_start) begin
                    n_phase = (na_zero || nb_zero) ? EP_FIN : EP_MUL;
                end
            end
            EP_MUL: begin
                if (r_cnt == '0) n_phase = EP_ROOT;
            end
            EP_ROOT: begin
                if (r_cnt == '0) n_phase = EP_DIV;
            end
            EP_DIV: begin
                if (r_cnt == '0) n_phase = EP_FIN;
            end
            EP_FIN: begin
                n_phase = EP_IDLE;
            end
            default: n_phase = EP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            EP_IDLE: begin
                if (i_start) begin
                    r_na  <= i_norm_a;
                    r_mpl <= i_norm_b;
                    r_acc <= '0;
                    r_cnt <= CW'(ACC_W - 1);
                    r_neg <= dot_neg;
                    r_dvd <= {dot_mag, {FRAC_BITS{1'b0}}};
                    r_big <= 1'b0;
                    // both norms zero counts as identical vectors
                    r_q   <= (na_zero && nb_zero) ? ONE_Q14 : '0;
                end
            end
            EP_MUL: begin
                r_acc <= au_sum[PW-1:0];
                r_mpl <= {r_mpl[ACC_W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    r_cnt  <= CW'(ACC_W - 1);
                    r_rem  <= '0;
                    r_root <= '0;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
            EP_ROOT: begin
                r_root <= {r_root[ACC_W-2:0], ~au_borrow};
                r_acc  <= {r_acc[PW-3:0], 2'b00};
                if (r_cnt == '0) begin
                    r_cnt <= CW'(DW - 1);
                    r_rem <= '0;
                end else begin
                    r_rem <= au_borrow ? root_sh : au_sum[RW-1:0];
                    r_cnt <= r_cnt - CW'(1);
                end
            end
            EP_DIV: begin
                r_rem <= au_borrow ? RW'(div_sh) : au_sum[RW-1:0];
                r_q   <= {r_q[SIM_W-2:0], ~au_borrow};
                r_big <= r_big | r_q[SIM_W-1];
                r_dvd <= {r_dvd[DW-2:0], 1'b0};
                r_cnt <= r_cnt - CW'(1);
            end
            EP_FIN: begin
                r_result <= r_neg ? $signed(~q_mag + SIM_W'(1)) : $signed(q_mag);
            end
            default: ;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ src/vector_cosine_similarity_core.sv @@
// a pair without the last mark holds the input side through accept, then three
// passes of the single element multiplier and an add
// a last pair's result waits on the bit-serial product, root and divide loops
// no new element pair is taken while busy
// reset clears accumulators, sequencer and output valid; no clearing pass
// ----------------------------------------------------------------------------
// vector_cosine_similarity_core
// Streaming cosine similarity of two signed vectors, one element pair per
// item, q1.14 result on the last pair.
// ----------------------------------------------------------------------------
module vector_cosine_similarity_core #(
    parameter int ELEM_WIDTH = vcsim_pkg::ELEM_WIDTH_DEF,
    parameter int MAX_LENGTH = vcsim_pkg::MAX_LENGTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [ELEM_WIDTH-1:0]       i_elem_a,
    input  logic signed [ELEM_WIDTH-1:0]       i_elem_b,
    input  logic                               i_last_elem,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [vcsim_pkg::SIM_W-1:0] o_similarity
);
    import vcsim_pkg::*;

    localparam int ACC_W = 2 * ELEM_WIDTH - 1 + $clog2(MAX_LENGTH);
    localparam int PRW   = 2 * ELEM_WIDTH;

    t_state r_state;
    t_state n_state;

    logic signed [ELEM_WIDTH-1:0] r_a;
    logic signed [ELEM_WIDTH-1:0] r_b;
    logic                         r_last;
    logic signed [PRW-1:0]        r_prod;
    logic signed [ACC_W-1:0]      r_dot;
    logic [ACC_W-1:0]             r_na;
    logic [ACC_W-1:0]             r_nb;
    logic                         r_out_valid;
    logic signed [SIM_W-1:0]      r_sim;

    logic signed [ELEM_WIDTH-1:0] mul_x;
    logic signed [ELEM_WIDTH-1:0] mul_y;
    logic signed [PRW-1:0]        mul_p;
    logic signed [ACC_W:0]        dot_sum;
    logic [ACC_W:0]               norm_sum_a;
    logic [ACC_W:0]               norm_sum_b;
    logic signed [ACC_W-1:0]      dot_sat;
    logic [ACC_W-1:0]             na_sat;
    logic [ACC_W-1:0]             nb_sat;
    logic                         accept;
    logic                         load_out;
    logic                         eng_start;
    logic                         eng_done;
    logic signed [SIM_W-1:0]      eng_result;

    // one multiplier: a*b, then a*a, then b*b
    assign mul_x = (r_state == ST_MUL_BB) ? r_b : r_a;
    assign mul_y = (r_state == ST_MUL_AA) ? r_a : r_b;
    assign mul_p = mul_x * mul_y;

    assign dot_sum    = $signed({r_dot[ACC_W-1], r_dot}) + (ACC_W+1)'(r_prod);
    assign norm_sum_a = {1'b0, r_na} + (ACC_W+1)'($unsigned(r_prod));
    assign norm_sum_b = {1'b0, r_nb} + (ACC_W+1)'($unsigned(r_prod));

    always_comb begin
        dot_sat = dot_sum[ACC_W-1:0];
        if (dot_sum[ACC_W] != dot_sum[ACC_W-1]) begin
            dot_sat = dot_sum[ACC_W] ? $signed({1'b1, {(ACC_W-1){1'b0}}})
                                     : $signed({1'b0, {(ACC_W-1){1'b1}}});
        end
    end

    assign na_sat = norm_sum_a[ACC_W] ? '1 : norm_sum_a[ACC_W-1:0];
    assign nb_sat = norm_sum_b[ACC_W] ? '1 : norm_sum_b[ACC_W-1:0];

    assign accept    = i_valid && (r_state == ST_IDLE);
    assign load_out  = (r_state == ST_DONE) && (!r_out_valid || i_ready);
    assign eng_start = (r_state == ST_START);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_MUL_AB;
            end
            ST_MUL_AB: n_state = ST_MUL_AA;
            ST_MUL_AA: n_state = ST_MUL_BB;
            ST_MUL_BB: n_state = ST_ACC_NB;
            ST_ACC_NB: n_state = r_last ? ST_START : ST_IDLE;
            ST_START:  n_state = ST_CALC;
            ST_CALC: begin
                if (eng_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // accumulators and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot       <= '0;
            r_na        <= '0;
            r_nb        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_dot <= '0;
                r_na  <= '0;
                r_nb  <= '0;
            end else if (r_state == ST_MUL_AA) begin
                r_dot <= dot_sat;
            end else if (r_state == ST_MUL_BB) begin
                r_na <= na_sat;
            end else if (r_state == ST_ACC_NB) begin
                r_nb <= nb_sat;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (accept) begin
            r_a    <= i_elem_a;
            r_b    <= i_elem_b;
            r_last <= i_last_elem;
        end
        if (load_out) begin
            r_sim <= eng_result;
        end
    end

    vcsim_engine #(
        .ACC_W (ACC_W)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (eng_start),
        .i_dot    (r_dot),
        .i_norm_a (r_na),
        .i_norm_b (r_nb),
        .o_done   (eng_done),
        .o_result (eng_result)
    );

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_similarity = r_sim;

endmodule

@@ src/vcsim_checker.sv @@
// ----------------------------------------------------------------------------
// vcsim_port_checks
// Port-level checks of the cosine similarity core, bound to the top level.
// ----------------------------------------------------------------------------
module vcsim_port_checks #(
    parameter int ELEM_WIDTH = vcsim_pkg::ELEM_WIDTH_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic signed [ELEM_WIDTH-1:0]       i_elem_a,
    input logic signed [ELEM_WIDTH-1:0]       i_elem_b,
    input logic                               i_last_elem,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic signed [vcsim_pkg::SIM_W-1:0] o_similarity
);
    import vcsim_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_similarity))
        else $error("result changed or dropped while stalled");

    // result stays within plus and minus one
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_similarity <= SIM_MAX) && (o_similarity >= SIM_MIN))
        else $error("similarity out of range");

    // the sequencer is busy for the cycle after an item is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after an accepted item");

    // a waiting input item holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_elem_a) && $stable(i_elem_b)
            && $stable(i_last_elem))
        else $error("input item changed or dropped while waiting");

    // reset clears output valid and leaves the core ready
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("output valid or busy state survived reset");

endmodule

bind vector_cosine_similarity_core vcsim_port_checks #(
    .ELEM_WIDTH (ELEM_WIDTH)
) u_vcsim_port_checks (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_elem_a     (i_elem_a),
    .i_elem_b     (i_elem_b),
    .i_last_elem  (i_last_elem),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_similarity (o_similarity)
);

@@ test/vcsim_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcsim_checker
// Watches both channels of the cosine similarity core, keeps its own copy of
// the three accumulators, predicts the q1.14 similarity of every vector pair
// and compares each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module vcsim_checker (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    input  logic                                        i_in_ready,
    input  logic signed [vcsim_pkg::ELEM_WIDTH_DEF-1:0] i_elem_a,
    input  logic signed [vcsim_pkg::ELEM_WIDTH_DEF-1:0] i_elem_b,
    input  logic                                        i_last_elem,
    input  logic                                        i_out_valid,
    input  logic                                        i_out_ready,
    input  logic signed [vcsim_pkg::SIM_W-1:0]          i_similarity,
    output int                                          o_fail_count,
    output int                                          o_pending,
    output int                                          o_result_count
);
    import vcsim_pkg::*;

    localparam longint DOT_HI  = (64'sd1 <<< 42) - 64'sd1;
    localparam longint DOT_LO  = -(64'sd1 <<< 42);
    localparam longint NORM_HI = (64'sd1 <<< 43) - 64'sd1;

    longint dot_sum;
    longint norm_a_sum;
    longint norm_b_sum;
    longint pair_ab;

    logic signed [SIM_W-1:0] sim_expected_q[$];
    logic signed [SIM_W-1:0] sim_want;

    // exact floor(sqrt(na*nb)) by bitwise trial, then truncating divide
    function automatic logic signed [SIM_W-1:0] cosine_q14(input longint dot,
                                                          input longint na,
                                                          input longint nb);
        bit [87:0] prod;
        bit [87:0] trial_sq;
        bit [43:0] root;
        bit [43:0] trial;
        bit [63:0] mag;
        bit [63:0] quot;
        if (na == 0 && nb == 0) return SIM_MAX;
        if (na == 0 || nb == 0) return '0;
        prod = 88'(na) * 88'(nb);
        root = '0;
        for (int k = 43; k >= 0; k--) begin
            trial    = root | (44'd1 << k);
            trial_sq = 88'(trial) * 88'(trial);
            if (trial_sq <= prod) root = trial;
        end
        mag  = (dot < 0) ? 64'(-dot) : 64'(dot);
        quot = (mag << FRAC_BITS) / 64'(root);
        if (quot > 64'(SIM_MAX)) quot = 64'(SIM_MAX);
        return (dot < 0) ? -SIM_W'(quot) : SIM_W'(quot);
    endfunction

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_result_count = 0;
        dot_sum        = 0;
        norm_a_sum     = 0;
        norm_b_sum     = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dot_sum    = 0;
            norm_a_sum = 0;
            norm_b_sum = 0;
            sim_expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (sim_expected_q.size() == 0) begin
                    $display("%0t: unexpected similarity item, expected none, got %0d",
                             $time, i_similarity);
                    o_fail_count++;
                end else begin
                    sim_want = sim_expected_q.pop_front();
                    if (i_similarity !== sim_want) begin
                        $display("%0t: similarity mismatch, expected %0d, got %0d",
                                 $time, sim_want, i_similarity);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                pair_ab = longint'(i_elem_a) * longint'(i_elem_b);
                dot_sum = dot_sum + pair_ab;
                if (dot_sum > DOT_HI) dot_sum = DOT_HI;
                if (dot_sum < DOT_LO) dot_sum = DOT_LO;
                norm_a_sum = norm_a_sum + longint'(i_elem_a) * longint'(i_elem_a);
                if (norm_a_sum > NORM_HI) norm_a_sum = NORM_HI;
                norm_b_sum = norm_b_sum + longint'(i_elem_b) * longint'(i_elem_b);
                if (norm_b_sum > NORM_HI) norm_b_sum = NORM_HI;
                if (i_last_elem) begin
                    sim_expected_q = {sim_expected_q,
                                      cosine_q14(dot_sum, norm_a_sum, norm_b_sum)};
                    dot_sum    = 0;
                    norm_a_sum = 0;
                    norm_b_sum = 0;
                end
            end
            o_pending = sim_expected_q.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives element pairs into the cosine similarity core with random gaps and
// output back-pressure: directed corner vectors, then randomly shaped
// vectors. The checker judges every result.
// ----------------------------------------------------------------------------
module tb_top;
    import vcsim_pkg::*;

    localparam logic signed [ELEM_WIDTH_DEF-1:0] E_MIN = 16'sh8000;
    localparam logic signed [ELEM_WIDTH_DEF-1:0] E_MAX = 16'sh7fff;
    localparam int RANDOM_ITEMS = 1080;
    localparam int HOLD_CYCLES  = 1500;

    typedef enum int {
        VS_RANDOM,
        VS_SMALL,
        VS_SAME,
        VS_NEGATED,
        VS_NEAR,
        VS_ZERO_A,
        VS_ZERO_B,
        VS_ZERO_BOTH,
        VS_EXTREME
    } t_vec_style;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [ELEM_WIDTH_DEF-1:0] elem_a;
    logic signed [ELEM_WIDTH_DEF-1:0] elem_b;
    logic last_elem;
    logic out_valid;
    logic out_ready;
    logic signed [SIM_W-1:0] similarity;

    int  fail_count;
    int  pending;
    int  result_count;
    int  pair_count;
    int  vector_count;
    bit  no_idle;
    bit  hold_req;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    vector_cosine_similarity_core i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_elem_a     (elem_a),
        .i_elem_b     (elem_b),
        .i_last_elem  (last_elem),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_similarity (similarity)
    );

    vcsim_checker u_chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_elem_a       (elem_a),
        .i_elem_b       (elem_b),
        .i_last_elem    (last_elem),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_similarity   (similarity),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // mostly no gap, some short, a few long
    function automatic int idle_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [ELEM_WIDTH_DEF-1:0] extreme_val();
        case ($urandom_range(0, 4))
            0: return E_MIN;
            1: return E_MAX;
            2: return -16'sd1;
            3: return 16'sd1;
            default: return 16'sd0;
        endcase
    endfunction

    task automatic send_pair(input logic signed [ELEM_WIDTH_DEF-1:0] a,
                             input logic signed [ELEM_WIDTH_DEF-1:0] b,
                             input logic is_last);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        elem_a    <= a;
        elem_b    <= b;
        last_elem <= is_last;
        do @(posedge clk); while (!in_ready);
        pair_count++;
        if (is_last) vector_count++;
    endtask

    task automatic send_vector(input int len, input t_vec_style style);
        logic signed [ELEM_WIDTH_DEF-1:0] a;
        logic signed [ELEM_WIDTH_DEF-1:0] b;
        for (int i = 0; i < len; i++) begin
            a = 16'($urandom);
            b = 16'($urandom);
            case (style)
                VS_SMALL: begin
                    a = 16'(int'($urandom_range(0, 16)) - 8);
                    b = 16'(int'($urandom_range(0, 16)) - 8);
                end
                VS_SAME:      b = a;
                VS_NEGATED:   b = -a;
                VS_NEAR:      b = a + 16'(int'($urandom_range(0, 6)) - 3);
                VS_ZERO_A:    a = '0;
                VS_ZERO_B:    b = '0;
                VS_ZERO_BOTH: begin
                    a = '0;
                    b = '0;
                end
                VS_EXTREME: begin
                    a = extreme_val();
                    b = extreme_val();
                end
                default: ;
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        @(posedge clk);
        while (pending != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
    endtask

    // receiver: random stalls, plus one long hold on request
    initial begin
        out_ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                int stall;
                stall = idle_len();
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    initial begin
        int rnd_start;
        int len;
        int r;
        int vec_idx;
        t_vec_style style;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        elem_a    <= '0;
        elem_b    <= '0;
        last_elem <= 1'b0;
        no_idle      = 1'b0;
        hold_req     = 1'b0;
        pair_count   = 0;
        vector_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single element vectors and extremes
        send_pair(16'sd1, 16'sd1, 1'b1);
        send_pair(E_MIN, E_MIN, 1'b1);
        send_pair(E_MAX, E_MAX, 1'b1);
        send_pair(E_MIN, E_MAX, 1'b1);
        send_pair(16'sh5555, -16'sh5556, 1'b1);
        // both norms zero, then only one norm zero
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd5, 1'b0);
        send_pair(16'sd0, -16'sd3, 1'b1);
        send_pair(16'sd7, 16'sd0, 1'b1);
        // antiparallel and orthogonal
        send_pair(16'sd3, -16'sd3, 1'b0);
        send_pair(16'sd4, -16'sd4, 1'b1);
        send_pair(16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        // floor of the root lifts the quotient to exactly one, both signs; then a nearly antiparallel extreme vector
        send_pair(16'sd1, 16'sd1, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        send_pair(16'sd1, -16'sd1, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        send_pair(E_MAX, E_MIN, 1'b0);
        send_pair(E_MIN, E_MAX, 1'b0);
        send_pair(16'shaaaa, 16'sh5555, 1'b1);

        rnd_start = pair_count;
        vec_idx   = 0;
        while (pair_count - rnd_start < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 15)      len = 1;
            else if (r < 80) len = $urandom_range(2, 8);
            else if (r < 95) len = $urandom_range(9, 30);
            else             len = $urandom_range(31, 100);
            r = $urandom_range(0, 99);
            if (r < 30)      style = VS_RANDOM;
            else if (r < 42) style = VS_SMALL;
            else if (r < 54) style = VS_SAME;
            else if (r < 64) style = VS_NEGATED;
            else if (r < 76) style = VS_NEAR;
            else if (r < 81) style = VS_ZERO_A;
            else if (r < 86) style = VS_ZERO_B;
            else if (r < 89) style = VS_ZERO_BOTH;
            else             style = VS_EXTREME;

            // back-pressure burst: receiver holds while vectors keep coming
            if (vec_idx == 20) begin
                hold_req = 1'b1;
                no_idle  = 1'b1;
            end
            if (vec_idx == 28) no_idle = 1'b0;
            // sender waits until everything is out
            if (vec_idx == 60) begin
                in_valid <= 1'b0;
                drain_results();
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            // stretch with no gaps on either side
            if (vec_idx == 80) no_idle = 1'b1;
            if (vec_idx == 100) no_idle = 1'b0;

            send_vector(len, style);
            vec_idx++;
        end

        in_valid <= 1'b0;
        drain_results();
        repeat (200) @(posedge clk);

        $display("covered %0d element pairs in %0d vectors: corners, zero norms,",
                 pair_count, vector_count);
        $display("random shapes under long and short stalls; %0d results checked",
                 result_count);
        if (pending != 0)
            $display("%0t: %0d similarity results still expected, none arrived",
                     $time, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ vector_cosine_similarity_core.f @@
src/vcsim_pkg.sv
src/vcsim_engine.sv
src/vector_cosine_similarity_core.sv
src/vcsim_checker.sv
test/vcsim_checker.sv
test/tb_top.sv
